[design/srpr_pkg.sv]
// Package for the servo reply packet receiver: beat payload structs,
// operation and status codes, and the frame parser phase type.
// No dependencies.
package srpr_pkg;

  localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
  localparam logic [7:0]  LEN_OVERHEAD  = 8'd2;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HEADER   = 3'd1,
    ST_ID       = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_t;

  localparam logic KIND_PARAM = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_HDR2  = 3'd2,
    PH_ID    = 3'd3,
    PH_LEN   = 3'd4,
    PH_ERR   = 3'd5,
    PH_PARAM = 3'd6,
    PH_CSUM  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] expected_id;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] param_byte;
    logic [7:0] param_index;
    logic [7:0] servo_error;
    logic [7:0] param_count;
    logic [2:0] status;
  } out_item_t;

endpackage

[design/servo_reply_packet_receiver.sv]
// Servo reply packet receiver: parses a status frame byte by byte.
// A result appears in the output register in the cycle after its input beat.
// Throughput: one input beat per cycle; a waiting result does not block input
// while the downstream side takes it in the same cycle.
// Reset (rst_n, synchronous, active low): idle, all counters and sums cleared,
// timeout register back to 3000 ticks. Depends on srpr_pkg.
module servo_reply_packet_receiver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srpr_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output srpr_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_timeout_ticks
);
  import srpr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] wanted_id_r, wanted_id_nxt;
  logic [15:0] idle_ticks_r, idle_ticks_nxt;
  logic [7:0] first_header_r, first_header_nxt;
  logic [7:0] params_left_r, params_left_nxt;
  logic [7:0] params_seen_r, params_seen_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] held_error_r, held_error_nxt;
  logic [15:0] timeout_r;

  logic       out_valid_r;
  out_item_t  out_item_r, result_nxt;
  logic       result_fire;

  logic       in_fire;
  op_t        op;
  logic [7:0] b;
  logic [15:0] ticks_inc;
  logic       timed_out;
  logic       header_bad;
  logic       id_bad;
  logic       csum_ok;
  logic [7:0] sum_plus_b;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign op         = op_t'(in_item.operation);
  assign b          = in_item.rx_byte;
  assign ticks_inc  = (idle_ticks_r == TICKS_MAX) ? idle_ticks_r : idle_ticks_r + 16'd1;
  assign timed_out  = ticks_inc >= timeout_r;
  assign header_bad = (first_header_r != HEADER_BYTE) || (b != HEADER_BYTE);
  assign id_bad     = b != wanted_id_r;
  assign csum_ok    = ~running_sum_r == b;
  assign sum_plus_b = running_sum_r + b;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      case (op)
        OP_ARM: phase_nxt = PH_HDR1;
        OP_TICK: begin
          if (phase_r != PH_IDLE && timed_out) phase_nxt = PH_IDLE;
        end
        OP_BYTE: begin
          case (phase_r)
            PH_IDLE:  phase_nxt = PH_IDLE;
            PH_HDR1:  phase_nxt = PH_HDR2;
            PH_HDR2:  phase_nxt = header_bad ? PH_IDLE : PH_ID;
            PH_ID:    phase_nxt = id_bad ? PH_IDLE : PH_LEN;
            PH_LEN:   phase_nxt = PH_ERR;
            PH_ERR:   phase_nxt = (params_left_r != 8'd0) ? PH_PARAM : PH_CSUM;
            PH_PARAM: phase_nxt = (params_left_r == 8'd1) ? PH_CSUM : PH_PARAM;
            PH_CSUM:  phase_nxt = PH_IDLE;
            default:  phase_nxt = PH_IDLE;
          endcase
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Datapath updates and the result beat.
  always_comb begin
    wanted_id_nxt    = wanted_id_r;
    idle_ticks_nxt   = idle_ticks_r;
    first_header_nxt = first_header_r;
    params_left_nxt  = params_left_r;
    params_seen_nxt  = params_seen_r;
    running_sum_nxt  = running_sum_r;
    held_error_nxt   = held_error_r;
    result_fire      = 1'b0;
    result_nxt.result_kind = KIND_END;
    result_nxt.param_byte  = 8'd0;
    result_nxt.param_index = 8'd0;
    result_nxt.servo_error = held_error_r;
    result_nxt.param_count = params_seen_r;
    result_nxt.status      = ST_OK;
    if (in_fire) begin
      case (op)
        OP_ARM: begin
          wanted_id_nxt    = in_item.expected_id;
          idle_ticks_nxt   = 16'd0;
          first_header_nxt = 8'd0;
          params_left_nxt  = 8'd0;
          params_seen_nxt  = 8'd0;
          running_sum_nxt  = 8'd0;
          held_error_nxt   = 8'd0;
        end
        OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            idle_ticks_nxt = ticks_inc;
            if (timed_out) begin
              result_fire       = 1'b1;
              result_nxt.status = ST_TIMEOUT;
            end
          end
        end
        OP_BYTE: begin
          if (phase_r != PH_IDLE) idle_ticks_nxt = 16'd0;
          case (phase_r)
            PH_IDLE: ;
            PH_HDR1: first_header_nxt = b;
            PH_HDR2: begin
              if (header_bad) begin
                result_fire       = 1'b1;
                result_nxt.status = ST_HEADER;
              end
            end
            PH_ID: begin
              if (id_bad) begin
                result_fire       = 1'b1;
                result_nxt.status = ST_ID;
              end else begin
                running_sum_nxt = b;
              end
            end
            PH_LEN: begin
              running_sum_nxt = sum_plus_b;
              params_left_nxt = (b >= LEN_OVERHEAD) ? b - LEN_OVERHEAD : 8'd0;
            end
            PH_ERR: begin
              running_sum_nxt = sum_plus_b;
              held_error_nxt  = b;
            end
            PH_PARAM: begin
              running_sum_nxt        = sum_plus_b;
              params_seen_nxt        = params_seen_r + 8'd1;
              params_left_nxt        = params_left_r - 8'd1;
              result_fire            = 1'b1;
              result_nxt.result_kind = KIND_PARAM;
              result_nxt.param_byte  = b;
              result_nxt.param_index = params_seen_r;
              result_nxt.servo_error = 8'd0;
              result_nxt.param_count = 8'd0;
            end
            PH_CSUM: begin
              result_fire       = 1'b1;
              result_nxt.status = csum_ok ? ST_OK : ST_CHECKSUM;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      wanted_id_r    <= 8'd0;
      idle_ticks_r   <= 16'd0;
      first_header_r <= 8'd0;
      params_left_r  <= 8'd0;
      params_seen_r  <= 8'd0;
      running_sum_r  <= 8'd0;
      held_error_r   <= 8'd0;
      timeout_r      <= TIMEOUT_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      wanted_id_r    <= wanted_id_nxt;
      idle_ticks_r   <= idle_ticks_nxt;
      first_header_r <= first_header_nxt;
      params_left_r  <= params_left_nxt;
      params_seen_r  <= params_seen_nxt;
      running_sum_r  <= running_sum_nxt;
      held_error_r   <= held_error_nxt;
      if (cfg_valid && cfg_ready) timeout_r <= cfg_timeout_ticks;
      if (result_fire)    out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) out_item_r <= result_nxt;
  end

endmodule
